FILE: hw/rtl/cc8_pkg.sv
package cc8_pkg;

   localparam int unsigned KeyRegCount  = 4;
   localparam int unsigned KeyIdxWidth  = $clog2(KeyRegCount);
   localparam int unsigned RoundCount   = 8;
   localparam int unsigned StageCount   = 2 * RoundCount;
   localparam int unsigned PairCount    = 8;
   localparam int unsigned PairIdxWidth = $clog2(PairCount);

   localparam logic [KeyIdxWidth-1:0] KeyIdx01 = KeyIdxWidth'(0);
   localparam logic [KeyIdxWidth-1:0] KeyIdx23 = KeyIdxWidth'(1);
   localparam logic [KeyIdxWidth-1:0] KeyIdx45 = KeyIdxWidth'(2);
   localparam logic [KeyIdxWidth-1:0] KeyIdx67 = KeyIdxWidth'(3);

   localparam logic [PairIdxWidth-1:0] LastPairIdx = PairIdxWidth'(PairCount - 1);

   localparam logic [31:0] Sigma0 = 32'h6170_7865;
   localparam logic [31:0] Sigma1 = 32'h3320_646e;
   localparam logic [31:0] Sigma2 = 32'h7962_2d32;
   localparam logic [31:0] Sigma3 = 32'h6b20_6574;

   typedef logic [15:0][31:0] state_type;
   typedef logic [3:0][31:0]  tail_type;
   typedef logic [3:0][63:0]  key_type;

   // one half of a quarter-round on all four lanes: the 16/12 or the 8/7 step pair
   function automatic state_type qr_half(state_type s, logic diag, logic second);
      state_type   r;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [1:0]  jb;
      logic [1:0]  jc;
      logic [1:0]  jd;
      r = s;
      for (int j = 0; j < 4; j++) begin
         jb = 2'(j + (diag ? 1 : 0));
         jc = 2'(j + (diag ? 2 : 0));
         jd = 2'(j + (diag ? 3 : 0));
         a = r[j];
         b = r[{2'd1, jb}];
         c = r[{2'd2, jc}];
         d = r[{2'd3, jd}];
         a = a + b;
         d = d ^ a;
         d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
         c = c + d;
         b = b ^ c;
         b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
         r[j]            = a;
         r[{2'd1, jb}]   = b;
         r[{2'd2, jc}]   = c;
         r[{2'd3, jd}]   = d;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/cc8_req_if.sv
interface cc8_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] nonce_low;
   logic [31:0] nonce_top;
   logic [31:0] block_counter;

   modport source (output valid, output nonce_low, output nonce_top,
                   output block_counter, input ready);
   modport sink   (input valid, input nonce_low, input nonce_top,
                   input block_counter, output ready);
endinterface

FILE: hw/rtl/cc8_rsp_if.sv
interface cc8_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] keystream_pair;
   logic [2:0]  pair_index;
   logic        last_pair;

   modport source (output valid, output keystream_pair, output pair_index,
                   output last_pair, input ready);
   modport sink   (input valid, input keystream_pair, input pair_index,
                   input last_pair, output ready);
endinterface

FILE: hw/rtl/chacha8_keystream_block.sv
// ChaCha8 keystream generator, 96-bit nonce and 32-bit block counter.
// Load the 256-bit key through the csr_ write port (index 0..3, key words
// 2i in the low half and 2i+1 in the high half) while no transaction is in
// flight. Each req_chan transaction carries nonce and block counter; the block
// returns eight rsp_chan transactions, pair_index 0..7, the keystream words
// 2k and 2k+1 packed little-endian, last_pair set on the eighth.
// The rounds run in a 16-stage pipeline, one half quarter-round per stage on
// all four lanes, followed by the feed-forward add into an output shift
// register. A request passes the stage registers 0..15, then the output
// register; after the first pair the rest follow one per cycle while
// rsp_chan.ready is high. The request rate is set by the single 64-bit
// result port; up to 17 requests may sit in the pipeline.
// When rsp_chan.ready is low the output register holds its pair and the
// pipeline fills and then drops req_chan.ready; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and clears the key.
module chacha8_keystream_block
   import cc8_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [KeyIdxWidth-1:0] csr_index,
   input  logic [63:0]            csr_wdata,
   cc8_req_if.sink                req_chan,
   cc8_rsp_if.source              rsp_chan
);

   key_type   key_ff;
   key_type   key_in;

   state_type st_ff [StageCount];
   state_type st_in [StageCount];
   tail_type  tail_ff [StageCount];
   tail_type  tail_in [StageCount];
   logic [StageCount-1:0] vld_ff;
   logic [StageCount-1:0] vld_in;
   logic [StageCount-1:0] adv;

   logic [511:0]            blk_ff;
   logic [511:0]            blk_in;
   logic [PairIdxWidth-1:0] idx_ff;
   logic [PairIdxWidth-1:0] idx_in;
   logic                    out_vld_ff;
   logic                    out_vld_in;
   logic                    load;
   logic                    take;
   state_type               init;
   state_type               start;
   state_type               fin;

   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            KeyIdx01: key_in[0] = csr_wdata;
            KeyIdx23: key_in[1] = csr_wdata;
            KeyIdx45: key_in[2] = csr_wdata;
            KeyIdx67: key_in[3] = csr_wdata;
            default:  key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      start     = '0;
      start[0]  = Sigma0;
      start[1]  = Sigma1;
      start[2]  = Sigma2;
      start[3]  = Sigma3;
      for (int i = 0; i < 4; i++) begin
         start[4 + 2 * i] = key_ff[i][31:0];
         start[5 + 2 * i] = key_ff[i][63:32];
      end
      start[12] = req_chan.block_counter;
      start[13] = req_chan.nonce_low[31:0];
      start[14] = req_chan.nonce_low[63:32];
      start[15] = req_chan.nonce_top;
   end

   // stall chain: a stage takes new data when empty or when it moves on
   assign take = out_vld_ff && rsp_chan.ready;
   assign load = vld_ff[StageCount-1] && (!out_vld_ff || (take && idx_ff == LastPairIdx));
   assign adv[StageCount-1] = !vld_ff[StageCount-1] || load;

   genvar g;
   for (g = 0; g < StageCount - 1; g++) begin : g_adv
      assign adv[g] = !vld_ff[g] || adv[g + 1];
   end

   assign req_chan.ready = adv[0];

   for (g = 0; g < StageCount; g++) begin : g_stage
      localparam logic Diag   = ((g / 2) % 2) == 1;
      localparam logic Second = (g % 2) == 1;

      if (g == 0) begin : g_first
         always_comb begin
            st_in[g]   = st_ff[g];
            tail_in[g] = tail_ff[g];
            vld_in[g]  = vld_ff[g];
            if (adv[g]) begin
               st_in[g]   = qr_half(start, Diag, Second);
               tail_in[g] = start[15:12];
               vld_in[g]  = req_chan.valid;
            end
         end
      end else begin : g_rest
         always_comb begin
            st_in[g]   = st_ff[g];
            tail_in[g] = tail_ff[g];
            vld_in[g]  = vld_ff[g];
            if (adv[g]) begin
               st_in[g]   = qr_half(st_ff[g - 1], Diag, Second);
               tail_in[g] = tail_ff[g - 1];
               vld_in[g]  = vld_ff[g - 1];
            end
         end
      end

      always_ff @(posedge clock) begin
         st_ff[g]   <= st_in[g];
         tail_ff[g] <= tail_in[g];
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_in[g];
         end
      end
   end

   always_comb begin
      init         = start;
      init[15:12]  = tail_ff[StageCount-1];
      for (int w = 0; w < 16; w++) begin
         fin[w] = st_ff[StageCount-1][w] + init[w];
      end
   end

   // output shift register: advance one pair per transaction
   always_comb begin
      blk_in     = blk_ff;
      idx_in     = idx_ff;
      out_vld_in = out_vld_ff;
      if (take) begin
         blk_in = {64'h0, blk_ff[511:64]};
         idx_in = idx_ff + PairIdxWidth'(1);
         if (idx_ff == LastPairIdx) begin
            out_vld_in = 1'b0;
         end
      end
      if (load) begin
         blk_in     = fin;
         idx_in     = '0;
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (reset) begin
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.keystream_pair = blk_ff[63:0];
   assign rsp_chan.pair_index     = idx_ff;
   assign rsp_chan.last_pair      = (idx_ff == LastPairIdx);

endmodule
